### hdl/vmt_pkg.sv
`timescale 1ns / 1ps

package vmt_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned NumLanes = 4;
  localparam int unsigned NumCols  = 4;
  localparam int unsigned NumRegs  = 8;
  localparam int unsigned RegW     = 64;
  localparam int unsigned RegIdxW  = 4;
  localparam int unsigned RegSelW  = $clog2(NumRegs);

  localparam int unsigned ProdW = 2 * DataW;
  localparam int unsigned PairW = ProdW + 1;
  localparam int unsigned SumW  = ProdW + 2;

  // Identity matrix, column major, two elements per register
  localparam logic [NumRegs-1:0][RegW-1:0] RegReset = '{
    64'h0001_0000_0000_0000,   // col3_rows23: m15 = 1.0
    64'h0000_0000_0000_0000,   // col3_rows01
    64'h0000_0000_0001_0000,   // col2_rows23: m10 = 1.0
    64'h0000_0000_0000_0000,   // col2_rows01
    64'h0000_0000_0000_0000,   // col1_rows23
    64'h0001_0000_0000_0000,   // col1_rows01: m5 = 1.0
    64'h0000_0000_0000_0000,   // col0_rows23
    64'h0000_0000_0001_0000    // col0_rows01: m0 = 1.0
  };

  typedef struct packed {
    logic signed [DataW-1:0] in_x;
    logic signed [DataW-1:0] in_y;
    logic signed [DataW-1:0] in_z;
    logic signed [DataW-1:0] in_w;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] out_x;
    logic signed [DataW-1:0] out_y;
    logic signed [DataW-1:0] out_z;
    logic signed [DataW-1:0] out_w;
    logic                    saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    sat;
  } lane_res_t;

  typedef struct packed {
    logic mul_en;
    logic pair_en;
    logic sum_en;
  } lane_ctrl_t;

endpackage

### hdl/vmt_lane.sv
`timescale 1ns / 1ps

// One output row: four products, a pair-add stage, then final add, shift and clip.
module vmt_lane (
  input  logic                                           clk_i,
  input  vmt_pkg::lane_ctrl_t                            ctrl_i,
  input  vmt_pkg::in_item_t                              vtx_i,
  input  logic [vmt_pkg::NumCols-1:0][vmt_pkg::DataW-1:0] coef_i,
  output vmt_pkg::lane_res_t                             res_o
);

  localparam int unsigned DataW = vmt_pkg::DataW;
  localparam int unsigned ProdW = vmt_pkg::ProdW;
  localparam int unsigned PairW = vmt_pkg::PairW;
  localparam int unsigned SumW  = vmt_pkg::SumW;
  localparam int unsigned FracB = vmt_pkg::FracBits;
  localparam int unsigned NumC  = vmt_pkg::NumCols;

  logic signed [DataW-1:0] comp [NumC];
  logic signed [ProdW-1:0] prod_d [NumC];
  logic signed [ProdW-1:0] prod_q [NumC];
  logic signed [PairW-1:0] pair_d [2];
  logic signed [PairW-1:0] pair_q [2];
  logic signed [SumW-1:0]  sum;
  logic [SumW-FracB-DataW:0] top_bits;
  logic                    clip;
  vmt_pkg::lane_res_t      res_d;
  vmt_pkg::lane_res_t      res_q;

  assign comp[0] = vtx_i.in_x;
  assign comp[1] = vtx_i.in_y;
  assign comp[2] = vtx_i.in_z;
  assign comp[3] = vtx_i.in_w;

  for (genvar c = 0; c < NumC; c++) begin : g_mul
    assign prod_d[c] = comp[c] * $signed(coef_i[c]);
  end

  assign pair_d[0] = PairW'(prod_q[0]) + PairW'(prod_q[1]);
  assign pair_d[1] = PairW'(prod_q[2]) + PairW'(prod_q[3]);

  // Exact sum, then floor shift; clip when the result's sign bit and the bits above it disagree
  assign sum      = SumW'(pair_q[0]) + SumW'(pair_q[1]);
  assign top_bits = sum[SumW-1:FracB+DataW-1];
  assign clip     = !((&top_bits) || !(|top_bits));

  always_comb begin
    res_d.sat = clip;
    if (!clip) begin
      res_d.value = sum[FracB+DataW-1:FracB];
    end else if (sum[SumW-1]) begin
      res_d.value = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      res_d.value = {1'b0, {(DataW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.pair_en) begin
      pair_q <= pair_d;
    end
    if (ctrl_i.sum_en) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

### hdl/vmt_merge.sv
`timescale 1ns / 1ps

// Collect the four row results into one transaction and hold it for the consumer.
module vmt_merge (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        valid_i,
  output logic                                        ready_o,
  input  vmt_pkg::lane_res_t [vmt_pkg::NumLanes-1:0]  res_i,
  output logic                                        out_valid_o,
  input  logic                                        out_ready_i,
  output vmt_pkg::out_item_t                          out_data_o
);

  logic               out_valid_q;
  vmt_pkg::out_item_t out_data_d;
  vmt_pkg::out_item_t out_data_q;
  logic               any_sat;

  always_comb begin
    any_sat = 1'b0;
    for (int l = 0; l < vmt_pkg::NumLanes; l++) begin
      any_sat = any_sat | res_i[l].sat;
    end
  end

  always_comb begin
    out_data_d.out_x     = res_i[0].value;
    out_data_d.out_y     = res_i[1].value;
    out_data_d.out_z     = res_i[2].value;
    out_data_d.out_w     = res_i[3].value;
    out_data_d.saturated = any_sat;
  end

  assign ready_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready_o) begin
      out_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### hdl/vertex_matrix_transform_top.sv
`timescale 1ns / 1ps

// Transforms one Q16.16 vertex (x, y, z, w) per clock by the 4x4 column-major
// matrix held in eight 64-bit registers (identity after reset). Four row lanes
// run side by side, each with four 32x32 multipliers; every transaction passes
// through registers for product, pair add, final add with shift and clip, and
// output, and a new one is accepted every cycle unless the output stalls. Each
// row is the exact sum shifted right by 16 (toward minus infinity) and clipped
// to 32 bits; saturated reports any clipped row. Write registers only while no
// transaction is in flight; writes to indexes of 8 and above are dropped.
module vertex_matrix_transform_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  vmt_pkg::in_item_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output vmt_pkg::out_item_t                  out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [vmt_pkg::RegIdxW-1:0]         cfg_index_i,
  input  logic [vmt_pkg::RegW-1:0]            cfg_data_i
);

  localparam int unsigned DataW = vmt_pkg::DataW;
  localparam int unsigned NumL  = vmt_pkg::NumLanes;
  localparam int unsigned NumC  = vmt_pkg::NumCols;

  logic [vmt_pkg::NumRegs-1:0][vmt_pkg::RegW-1:0] cfg_q;
  logic [NumL-1:0][NumC-1:0][DataW-1:0]            lane_coef;
  vmt_pkg::lane_res_t [NumL-1:0]                   lane_res;
  vmt_pkg::lane_ctrl_t                             ctrl;
  logic mul_v_q, pair_v_q, sum_v_q;
  logic merge_ready;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= vmt_pkg::RegReset;
    end else if (cfg_valid_i && (cfg_index_i < vmt_pkg::RegIdxW'(vmt_pkg::NumRegs))) begin
      cfg_q[cfg_index_i[vmt_pkg::RegSelW-1:0]] <= cfg_data_i;
    end
  end

  // Row r, column c uses element r + 4c: register 2c + r/2, half r%2
  for (genvar r = 0; r < NumL; r++) begin : g_row
    for (genvar c = 0; c < NumC; c++) begin : g_col
      assign lane_coef[r][c] = cfg_q[2*c + r/2][DataW*(r%2) +: DataW];
    end
  end

  // A stage advances when it is empty or the one after it moves
  assign ctrl.sum_en  = !sum_v_q  || merge_ready;
  assign ctrl.pair_en = !pair_v_q || ctrl.sum_en;
  assign ctrl.mul_en  = !mul_v_q  || ctrl.pair_en;
  assign in_ready_o   = ctrl.mul_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q  <= 1'b0;
      pair_v_q <= 1'b0;
      sum_v_q  <= 1'b0;
    end else begin
      if (ctrl.mul_en) begin
        mul_v_q <= in_valid_i;
      end
      if (ctrl.pair_en) begin
        pair_v_q <= mul_v_q;
      end
      if (ctrl.sum_en) begin
        sum_v_q <= pair_v_q;
      end
    end
  end

  for (genvar r = 0; r < NumL; r++) begin : g_lane
    vmt_lane u_lane (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .vtx_i  (in_data_i),
      .coef_i (lane_coef[r]),
      .res_o  (lane_res[r])
    );
  end

  vmt_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (sum_v_q),
    .ready_o     (merge_ready),
    .res_i       (lane_res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Input stalls only under output backpressure
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output backpressure");

  // A flagged transaction carries at least one clipped component
  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.saturated) |->
      (out_data_o.out_x == 32'sh7fff_ffff || out_data_o.out_x == 32'sh8000_0000 ||
       out_data_o.out_y == 32'sh7fff_ffff || out_data_o.out_y == 32'sh8000_0000 ||
       out_data_o.out_z == 32'sh7fff_ffff || out_data_o.out_z == 32'sh8000_0000 ||
       out_data_o.out_w == 32'sh7fff_ffff || out_data_o.out_w == 32'sh8000_0000))
    else $error("saturated set with no clipped component");

  // A new result comes only from a filled final lane stage
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(sum_v_q))
    else $error("output valid without a lane result");

endmodule
